FILE: rtl/servo_status_frame_parser_core_assert.svh
// Assertion macros shared by the checker module of the status-frame parser.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SERVO_STATUS_FRAME_PARSER_CORE_ASSERT_SVH
`define SERVO_STATUS_FRAME_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspf assertion failed");

`endif

FILE: rtl/sspf_pkg.sv
// Package for the servo status-frame parser: types, constants and field decoders.
// Depends on nothing; imported by every module of the parser.
`timescale 1ns / 1ps

package sspf_pkg;

    localparam logic [7:0] HeaderByte   = 8'hFF;
    localparam logic [7:0] MinLength    = 8'd3;
    localparam logic [7:0] BasicDataLen = 8'd8;
    localparam logic [7:0] ExtDataLen   = 8'd15;
    localparam logic [7:0] IdLimitReset = 8'd8;
    localparam int         PayloadDepth = 11;
    localparam int         PayloadIdxW  = $clog2(PayloadDepth);
    localparam int         OutDataW     = 96;
    localparam int         OutUserW     = 2;

    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_LENGTH = 6'b000010,
        PH_ERROR  = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CHECK  = 6'b010000,
        PH_DRAIN  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic               extended_valid;
        logic               basic_valid;
        logic signed [15:0] current;
        logic [7:0]         moving;
        logic [7:0]         temperature;
        logic [7:0]         voltage;
        logic signed [10:0] load;
        logic signed [15:0] speed;
        logic signed [15:0] position;
        logic [7:0]         servo_id;
    } result_t;

    function automatic logic signed [15:0] decode_sm16(input logic [15:0] raw);
        logic [15:0] mag;
        mag = {1'b0, raw[14:0]};
        return raw[15] ? -mag : mag;
    endfunction

    function automatic logic signed [10:0] decode_sm11(input logic [10:0] raw);
        logic [10:0] mag;
        mag = {1'b0, raw[9:0]};
        return raw[10] ? -mag : mag;
    endfunction

endpackage

FILE: rtl/sspf_parser.sv
// Byte-wide frame parser: header search, checksum, payload capture and field decode.
// Depends on sspf_pkg.
`timescale 1ns / 1ps

module sspf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              buffer_end,
    input  logic [7:0]        id_limit,
    output logic              emit,
    output sspf_pkg::result_t result
);
    import sspf_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] pos_reg, pos_next;
    logic       finished_reg, finished_next;
    logic [7:0] payload_reg [PayloadDepth];

    logic                   wr_en;
    logic [PayloadIdxW-1:0] wr_idx;
    logic [7:0]             pos_inc;
    logic [7:0]             body_len;
    logic [7:0]             sum_add;

    assign pos_inc  = pos_reg + 8'd1;
    assign body_len = len_reg - 8'd2;
    assign sum_add  = sum_reg + rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = pos_reg[PayloadIdxW-1:0];
        case (phase_reg)
            PH_SEARCH:
            begin
                if (finished_reg)
                begin
                    phase_next = PH_DRAIN;
                end
                else if (rx_byte == HeaderByte)
                begin
                    if (pos_reg < 8'd2)
                    begin
                        pos_next = pos_inc;
                    end
                end
                else if (pos_reg >= 8'd2)
                begin
                    id_next       = rx_byte;
                    sum_next      = rx_byte;
                    finished_next = 1'b1;
                    phase_next    = PH_LENGTH;
                end
                else
                begin
                    pos_next = 8'd0;
                end
            end
            PH_LENGTH:
            begin
                len_next   = rx_byte;
                sum_next   = sum_add;
                phase_next = (rx_byte < MinLength) ? PH_DRAIN : PH_ERROR;
            end
            PH_ERROR:
            begin
                sum_next   = sum_add;
                pos_next   = 8'd0;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (pos_reg < 8'd8)
                begin
                    wr_en = 1'b1;
                end
                else if (pos_reg == 8'd10)
                begin
                    wr_en  = 1'b1;
                    wr_idx = PayloadIdxW'(8);
                end
                else if (pos_reg == 8'd13)
                begin
                    wr_en  = 1'b1;
                    wr_idx = PayloadIdxW'(9);
                end
                else if (pos_reg == 8'd14)
                begin
                    wr_en  = 1'b1;
                    wr_idx = PayloadIdxW'(10);
                end
                sum_next = sum_add;
                pos_next = pos_inc;
                if (pos_inc >= body_len)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                emit       = (~sum_reg == rx_byte) && (id_reg != 8'd0) && (id_reg < id_limit);
                phase_next = PH_DRAIN;
            end
            PH_DRAIN:
            begin
                phase_next = PH_DRAIN;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase
        if (buffer_end)
        begin
            phase_next    = PH_SEARCH;
            pos_next      = 8'd0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            id_reg       <= 8'd0;
            len_reg      <= 8'd0;
            sum_reg      <= 8'd0;
            pos_reg      <= 8'd0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            payload_reg[wr_idx] <= rx_byte;
        end
    end

    always_comb
    begin
        result          = '0;
        result.servo_id = id_reg;
        if (body_len >= BasicDataLen)
        begin
            result.position    = decode_sm16({payload_reg[1], payload_reg[0]});
            result.speed       = decode_sm16({payload_reg[3], payload_reg[2]});
            result.load        = decode_sm11({payload_reg[5][2:0], payload_reg[4]});
            result.voltage     = payload_reg[6];
            result.temperature = payload_reg[7];
            result.basic_valid = 1'b1;
        end
        if (body_len >= ExtDataLen)
        begin
            result.moving         = payload_reg[8];
            result.current        = {payload_reg[10], payload_reg[9]};
            result.extended_valid = 1'b1;
        end
    end

endmodule

FILE: rtl/servo_status_frame_parser_core.sv
// Top level of the servo status-frame parser: input register, parser and result register.
// Depends on sspf_pkg and sspf_parser.
`timescale 1ns / 1ps

// The block takes one received byte per transfer and accepts a new byte in every
// cycle. A byte is held in an input register and handled by the parser from there;
// its result is loaded into the output register when the parser steps on the byte,
// so a result is offered on the master side once its checksum byte has passed
// both registers. A result waiting in the output register stalls only a byte that
// would give a further result; all other bytes keep flowing at one per cycle. The id
// limit is written through cfg_wr_en and cfg_wr_data and resets to 8.
module servo_status_frame_parser_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // rx_byte
    input  logic                               s_tlast,  // buffer_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // servo_id[7:0], position[23:8], speed[39:24], load[50:40], voltage[58:51],
    // temperature[66:59], moving[74:67], current[90:75], zero fill[95:91]
    output logic [sspf_pkg::OutDataW-1:0]      m_tdata,
    output logic [sspf_pkg::OutUserW-1:0]      m_tuser,  // extended_valid[1], basic_valid[0]
    input  logic                               cfg_wr_en,
    input  logic [7:0]                         cfg_wr_data
);
    import sspf_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic [7:0] id_limit_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic    emit;
    result_t result;
    logic    advance;

    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sspf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .buffer_end (in_last_reg),
        .id_limit   (id_limit_reg),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            id_limit_reg  <= IdLimitReset;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                id_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.current, out_reg.moving, out_reg.temperature,
                       out_reg.voltage, out_reg.load, out_reg.speed, out_reg.position,
                       out_reg.servo_id};
    assign m_tuser  = {out_reg.extended_valid, out_reg.basic_valid};

endmodule

FILE: rtl/sspf_checker.sv
// Port-level checker for the servo status-frame parser, bound to the top level.
// Depends on sspf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "servo_status_frame_parser_core_assert.svh"

module sspf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sspf_pkg::OutDataW-1:0] m_tdata,
    input logic [sspf_pkg::OutUserW-1:0] m_tuser
);
    import sspf_pkg::*;

    logic [OutDataW+OutUserW-1:0] m_word;

    assign m_word = {m_tuser, m_tdata};

    `SSPF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_word))
    `SSPF_ASSERT_NOW(a_id_nonzero, clk, rst_n, m_tvalid, m_tdata[7:0] != 8'd0)
    `SSPF_ASSERT_NOW(a_ext_needs_basic, clk, rst_n, m_tvalid && m_tuser[1], m_tuser[0])
    `SSPF_ASSERT_NOW(a_short_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata[OutDataW-1:8] == '0)

endmodule

bind servo_status_frame_parser_core sspf_checker u_sspf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
